[hw/rtl/ile_pkg.sv]
// Shared types and constants for the indexed list engine.
package ile_pkg;

  localparam int Depth = 16;
  localparam int WordWidth = 32;
  localparam int IdxW = $clog2(Depth);
  localparam int CntW = $clog2(Depth + 1);

  typedef logic [WordWidth-1:0] word_t;

  typedef enum logic [3:0] {
    MODE_APPEND  = 4'd0,
    MODE_INSERT  = 4'd1,
    MODE_REMOVE  = 4'd2,
    MODE_READ    = 4'd3,
    MODE_WRITE   = 4'd4,
    MODE_SEARCH  = 4'd5,
    MODE_MAX     = 4'd6,
    MODE_MIN     = 4'd7,
    MODE_REVERSE = 4'd8,
    MODE_ROTATE  = 4'd9
  } mode_t;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
  localparam logic [1:0] ST_EMPTY = 2'd3;

  typedef enum logic [1:0] {
    S_IDLE,
    S_ROT,
    S_SCAN,
    S_OUT
  } state_t;

  // Per-cycle command the controller sends to every cell.
  typedef enum logic [2:0] {
    OP_HOLD,
    OP_INSERT,
    OP_REMOVE,
    OP_WRITE,
    OP_REVERSE,
    OP_ROTATE
  } cell_op_t;

  typedef struct packed {
    cell_op_t         op;
    logic [IdxW-1:0]  pos;
    logic [CntW-1:0]  count;
    word_t            word;
  } cell_ctl_t;

  typedef struct packed {
    logic [3:0]  mode;
    logic [3:0]  position;
    logic [31:0] value;
    logic [7:0]  rotate_steps;
  } in_beat_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] data;
    logic [4:0]  found_index;
    logic [4:0]  entry_count;
  } out_beat_t;

endpackage

[hw/rtl/indexed_list_engine_top.sv]
// Top level of the indexed list engine: controller and the chain of cells.
//
//  channel | ports                        | direction
//  in      | in_valid, in_stall, in_beat  | items in
//  out     | out_valid, out_stall, out_beat | results out
//
// Most operations are applied when the item is accepted; the result is then presented in S_OUT.
// Max and min first walk the chain one cell a cycle in S_SCAN.
// Rotate by k first reduces k modulo count by repeated compare-and-subtract,
// then moves the chain one step a cycle.
// Reset clears the count and control; cell contents are undefined until written.
// A result held by out_stall blocks the next item until it is taken.
module indexed_list_engine_top
  import ile_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_beat_t  in_beat,
  output logic      out_valid,
  input  logic      out_stall,
  output out_beat_t out_beat
);

  state_t state_r, state_nxt;
  logic [CntW-1:0] count_r, count_nxt;
  logic [7:0] steps_r, steps_nxt;
  logic [IdxW-1:0] scan_r, scan_nxt;
  logic is_max_r, is_max_nxt;
  word_t best_r, best_nxt;
  out_beat_t res_r, res_nxt;
  cell_ctl_t ctl;
  word_t words [Depth];
  logic accept;
  logic [3:0] found_idx;
  logic found_hit;
  word_t in_word;
  word_t cand;
  logic better;
  logic [7:0] red_sub;
  logic rot_reduce;

  assign in_word = WordWidth'(signed'(in_beat.value));
  assign accept = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);
  assign out_valid = (state_r == S_OUT);
  assign out_beat = res_r;

  // Chain of cells
  for (genvar g = 0; g < Depth; g++) begin : g_cell
    word_t lw, rw, mw;
    logic [CntW-1:0] mi;
    assign mi = ctl.count - 1'b1 - CntW'(g);
    assign lw = (g == 0) ? words[0] : words[(g == 0) ? 0 : g - 1];
    assign rw = words[(g == Depth - 1) ? g : g + 1];
    assign mw = words[mi[IdxW-1:0]];
    ile_cell u_cell (
      .clk         (clk),
      .idx         (IdxW'(g)),
      .ctl         (ctl),
      .left_word   (lw),
      .right_word  (rw),
      .mirror_word (mw),
      .first_word  (words[0]),
      .word        (words[g])
    );
  end

  // First match among live cells
  always_comb begin
    found_hit = 1'b0;
    found_idx = '0;
    for (int i = Depth - 1; i >= 0; i--) begin
      if (CntW'(i) < count_r && words[i] == in_word) begin
        found_hit = 1'b1;
        found_idx = 4'(i);
      end
    end
  end

  assign cand = words[scan_r];
  assign better = is_max_r ? ($signed(cand) > $signed(best_r))
                           : ($signed(cand) < $signed(best_r));

  // Rotate step reduction: largest shifted count that fits in the steps left
  assign rot_reduce = (steps_r >= 8'(count_r));
  always_comb begin
    red_sub = '0;
    for (int j = 0; j < 8; j++) begin
      if ((12'(count_r) << j) <= 12'(steps_r)) red_sub = 8'(12'(count_r) << j);
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_beat.mode == MODE_ROTATE && in_beat.rotate_steps != 0 &&
              count_r > 1)
            state_nxt = S_ROT;
          else if ((in_beat.mode == MODE_MAX || in_beat.mode == MODE_MIN) &&
                   count_r > 1)
            state_nxt = S_SCAN;
          else
            state_nxt = S_OUT;
        end
      end
      S_ROT:  if (!rot_reduce && steps_r <= 8'd1) state_nxt = S_OUT;
      S_SCAN: if (CntW'(scan_r) + 1'b1 >= count_r) state_nxt = S_OUT;
      S_OUT:  if (!out_stall) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Datapath and cell commands
  always_comb begin
    ctl.op = OP_HOLD;
    ctl.pos = in_beat.position;
    ctl.count = count_r;
    ctl.word = in_word;
    count_nxt = count_r;
    steps_nxt = steps_r;
    scan_nxt = scan_r;
    is_max_nxt = is_max_r;
    best_nxt = best_r;
    res_nxt = res_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          res_nxt.status = ST_OK;
          res_nxt.data = '0;
          res_nxt.found_index = 5'h1f;
          case (in_beat.mode)
            MODE_APPEND, MODE_INSERT: begin
              ctl.pos = (in_beat.mode == MODE_APPEND) ? count_r[IdxW-1:0]
                                                       : in_beat.position;
              if (in_beat.mode == MODE_INSERT && CntW'(in_beat.position) > count_r)
                res_nxt.status = ST_RANGE;
              else if (count_r >= CntW'(Depth))
                res_nxt.status = ST_FULL;
              else begin
                ctl.op = OP_INSERT;
                count_nxt = count_r + 1'b1;
              end
            end
            MODE_REMOVE, MODE_READ, MODE_WRITE: begin
              if (CntW'(in_beat.position) >= count_r)
                res_nxt.status = ST_RANGE;
              else if (in_beat.mode == MODE_REMOVE) begin
                ctl.op = OP_REMOVE;
                count_nxt = count_r - 1'b1;
              end else if (in_beat.mode == MODE_WRITE)
                ctl.op = OP_WRITE;
              else
                res_nxt.data = 32'(signed'(words[in_beat.position]));
            end
            MODE_SEARCH: begin
              if (found_hit) res_nxt.found_index = {1'b0, found_idx};
            end
            MODE_MAX, MODE_MIN: begin
              if (count_r == 0) res_nxt.status = ST_EMPTY;
              else begin
                best_nxt = words[0];
                scan_nxt = IdxW'(1);
                is_max_nxt = (in_beat.mode == MODE_MAX);
                res_nxt.data = 32'(signed'(words[0]));
              end
            end
            MODE_REVERSE: ctl.op = OP_REVERSE;
            MODE_ROTATE: begin
              if (in_beat.rotate_steps != 0 && count_r == 0)
                res_nxt.status = ST_EMPTY;
              else
                steps_nxt = in_beat.rotate_steps;
            end
            default: ;
          endcase
          res_nxt.entry_count = count_nxt;
        end
      end
      S_ROT: begin
        // Reduce steps modulo count first, then rotate one step a cycle
        if (rot_reduce)
          steps_nxt = steps_r - red_sub;
        else if (steps_r != 0) begin
          ctl.op = OP_ROTATE;
          steps_nxt = steps_r - 1'b1;
        end
      end
      S_SCAN: begin
        if (better) begin
          best_nxt = cand;
          res_nxt.data = 32'(signed'(cand));
        end
        scan_nxt = scan_r + 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    steps_r <= steps_nxt;
    scan_r <= scan_nxt;
    is_max_r <= is_max_nxt;
    best_r <= best_nxt;
    res_r <= res_nxt;
  end

endmodule

[hw/rtl/ile_cell.sv]
// One list cell: holds a word, loaded from other cells or the command.
module ile_cell
  import ile_pkg::*;
(
  input  logic             clk,
  input  logic [IdxW-1:0]  idx,
  input  cell_ctl_t        ctl,
  input  word_t            left_word,
  input  word_t            right_word,
  input  word_t            mirror_word,
  input  word_t            first_word,
  output word_t            word
);

  word_t word_r;
  word_t word_nxt;
  logic [CntW-1:0] idx_w;
  logic [CntW-1:0] pos_w;

  assign idx_w = CntW'(idx);
  assign pos_w = CntW'(ctl.pos);

  // Neighbor selection per operation
  always_comb begin
    word_nxt = word_r;
    case (ctl.op)
      OP_INSERT: begin
        if (idx_w == pos_w) word_nxt = ctl.word;
        else if (idx_w > pos_w && idx_w <= ctl.count) word_nxt = left_word;
      end
      OP_REMOVE: begin
        if (idx_w >= pos_w && idx_w + 1'b1 < ctl.count) word_nxt = right_word;
      end
      OP_WRITE: begin
        if (idx_w == pos_w) word_nxt = ctl.word;
      end
      OP_REVERSE: begin
        if (idx_w < ctl.count) word_nxt = mirror_word;
      end
      OP_ROTATE: begin
        if (idx_w + 1'b1 < ctl.count) word_nxt = right_word;
        else if (idx_w + 1'b1 == ctl.count) word_nxt = first_word;
      end
      default: word_nxt = word_r;
    endcase
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

  assign word = word_r;

endmodule
